FILE: hw/rtl/gse_pkg.sv
// Shared types, constants and codes of the graph SIR epidemic engine.
`default_nettype none

package gse_pkg;

    // Graph and run limits
    localparam int NODES      = 64;
    localparam int MAX_ROUNDS = 127;

    // Field and counter widths
    localparam int IDX_W   = $clog2(NODES);
    localparam int NODE_W  = 6;
    localparam int ROW_W   = 64;
    localparam int CNT_W   = 7;
    localparam int PCT_W   = 7;
    localparam int ROUND_W = 7;
    localparam int SEED_W  = 32;

    // Draw scaling: low 16 LFSR bits times 100, keep the integer part
    localparam int DRAW_FRAC_W = 16;
    localparam int PROD_W      = DRAW_FRAC_W + PCT_W;
    localparam logic [SEED_W-1:0] LFSR_TAPS     = 32'h8020_0003;
    localparam logic [PCT_W-1:0]  PERCENT_SCALE = 7'd100;

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_SEL_W  = 3;

    localparam logic [REG_SEL_W-1:0] REG_INFECT_PERCENT  = 3'd0;
    localparam logic [REG_SEL_W-1:0] REG_RECOVER_PERCENT = 3'd1;
    localparam logic [REG_SEL_W-1:0] REG_NODE_COUNT      = 3'd2;
    localparam logic [REG_SEL_W-1:0] REG_SEED_NODE       = 3'd3;
    localparam logic [REG_SEL_W-1:0] REG_RANDOM_SEED     = 3'd4;

    // Register reset values
    localparam logic [PCT_W-1:0]  INFECT_RESET  = 7'd50;
    localparam logic [PCT_W-1:0]  RECOVER_RESET = 7'd80;
    localparam logic [CNT_W-1:0]  COUNT_RESET   = 7'd64;
    localparam logic [NODE_W-1:0] SEED_RESET    = 6'd0;
    localparam logic [SEED_W-1:0] RANDOM_RESET  = 32'd1;

    typedef struct packed {
        logic [PCT_W-1:0]  infect_percent;
        logic [PCT_W-1:0]  recover_percent;
        logic [CNT_W-1:0]  node_count;
        logic [NODE_W-1:0] seed_node;
        logic [SEED_W-1:0] random_seed;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic step;
    } draw_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROUND,
        ST_NODE_RD,
        ST_NODE_EVAL,
        ST_SCAN,
        ST_RECOVER,
        ST_EMIT_RD,
        ST_EMIT_PUT
    } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gse_ram.sv
// Generic single-write, single-read memory with registered read data.
`default_nettype none

module gse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/gse_draw_unit.sv
// Shared draw unit: Galois LFSR step, scale to 0..99, compare against a percent.
`default_nettype none

module gse_draw_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gse_pkg::draw_ctrl_t         ctrl,
    input  logic [gse_pkg::SEED_W-1:0]  seed,
    input  logic [gse_pkg::PCT_W-1:0]   percent,
    output logic                        hit
);

    import gse_pkg::*;

    logic [SEED_W-1:0] lfsr_reg;
    logic [SEED_W-1:0] lfsr_next;
    logic [SEED_W-1:0] lfsr_step;
    logic [PROD_W-1:0] product;
    logic [PCT_W-1:0]  draw;

    // Shift right, fold the taps back in when a one falls out
    assign lfsr_step = {1'b0, lfsr_reg[SEED_W-1:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : '0);
    assign product   = PROD_W'(lfsr_step[DRAW_FRAC_W-1:0]) * PROD_W'(PERCENT_SCALE);
    assign draw      = product[PROD_W-1:DRAW_FRAC_W];
    assign hit       = (draw < percent);

    always_comb
    begin
        lfsr_next = lfsr_reg;
        if (ctrl.load)
        begin
            lfsr_next = (seed == '0) ? SEED_W'(1) : seed;
        end
        else if (ctrl.step)
        begin
            lfsr_next = lfsr_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= RANDOM_RESET;
        end
        else
        begin
            lfsr_reg <= lfsr_next;
        end
    end

`ifndef SYNTHESIS
    a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != '0)
        else $error("draw LFSR reached the all-zero lockup state");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/gse_cfg_regs.sv
// APB-style configuration registers of the epidemic engine.
`default_nettype none

module gse_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gse_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gse_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gse_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output gse_pkg::cfg_t                  cfg
);

    import gse_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_SEL_W-1:0] reg_sel;
    logic                 wr_en;

    assign reg_sel = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_INFECT_PERCENT:  cfg_next.infect_percent  = pwdata[PCT_W-1:0];
                REG_RECOVER_PERCENT: cfg_next.recover_percent = pwdata[PCT_W-1:0];
                REG_NODE_COUNT:      cfg_next.node_count      = pwdata[CNT_W-1:0];
                REG_SEED_NODE:       cfg_next.seed_node       = pwdata[NODE_W-1:0];
                REG_RANDOM_SEED:     cfg_next.random_seed     = pwdata[SEED_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_INFECT_PERCENT:  prdata = APB_DATA_W'(cfg_reg.infect_percent);
            REG_RECOVER_PERCENT: prdata = APB_DATA_W'(cfg_reg.recover_percent);
            REG_NODE_COUNT:      prdata = APB_DATA_W'(cfg_reg.node_count);
            REG_SEED_NODE:       prdata = APB_DATA_W'(cfg_reg.seed_node);
            REG_RANDOM_SEED:     prdata = APB_DATA_W'(cfg_reg.random_seed);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.infect_percent  <= INFECT_RESET;
            cfg_reg.recover_percent <= RECOVER_RESET;
            cfg_reg.node_count      <= COUNT_RESET;
            cfg_reg.seed_node       <= SEED_RESET;
            cfg_reg.random_seed     <= RANDOM_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/graph_sir_epidemic_engine.sv
// Top level of the graph SIR epidemic engine: run sequencer, memories and ports.
//
// Usage: the input channel (in_valid/in_ready) takes one adjacency row per beat:
// row_index picks the row, neighbours holds its edge bits. Rows load at one beat
// per cycle while the block is idle. The beat with last_row set is stored and
// then starts a run from seed_node; in_ready stays low until the run's last
// result has been handed to the output register.
// A run has an init state and a closing round state, then per round a round state
// plus, for every node in use, a read state (round-memory and adjacency read) and a
// check state and, for each node infectious in that round, a scan over every node
// in use and a recovery state. The scan walks one neighbour per cycle through
// the single shared draw unit. After the last round, results stream out over the
// output channel (out_valid/out_ready), one per node in node order, each read from
// the round memory and then put into the output register; last_node marks the
// final one. A stalled receiver holds the output register and the emit sequencer
// waits; nothing is dropped. Configuration is to be written over the APB-style
// port only while idle; the block does not enforce this. Reset clears the
// sequencer, the node flags and the counters and loads the register reset values;
// the adjacency memory holds garbage until rows are written.
`default_nettype none

module graph_sir_epidemic_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gse_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [gse_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [gse_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    // Row input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [gse_pkg::NODE_W-1:0]      row_index,
    input  logic [gse_pkg::ROW_W-1:0]       neighbours,
    input  logic                            last_row,
    // Result output channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [gse_pkg::NODE_W-1:0]      node_index,
    output logic                            ever_infected,
    output logic [gse_pkg::ROUND_W-1:0]     final_round,
    output logic                            recovered,
    output logic [gse_pkg::ROUND_W-1:0]     rounds_run,
    output logic                            hit_limit,
    output logic                            last_node
);

    import gse_pkg::*;

    cfg_t       cfg;
    draw_ctrl_t draw_ctrl;
    logic [PCT_W-1:0] draw_percent;
    logic             draw_hit;

    state_t state_reg;
    state_t state_next;

    logic [IDX_W-1:0]   i_reg, i_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [ROUND_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0]   active_reg, active_next;
    logic [NODES-1:0]   inf_reg, inf_next;
    logic [NODES-1:0]   imm_reg, imm_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic               out_load;
    logic [NODE_W-1:0]  node_index_reg;
    logic               ever_infected_reg;
    logic [ROUND_W-1:0] final_round_reg;
    logic               recovered_reg;
    logic [ROUND_W-1:0] rounds_run_reg;
    logic               hit_limit_reg;
    logic               last_node_reg;

    // Memory ports
    logic               adj_we;
    logic               adj_re;
    logic [NODES-1:0]   adj_rdata;
    logic               rnd_we;
    logic [IDX_W-1:0]   rnd_waddr;
    logic [ROUND_W-1:0] rnd_wdata;
    logic               rnd_re;
    logic [IDX_W-1:0]   rnd_raddr;
    logic [ROUND_W-1:0] rnd_rdata;

    // Run-wide decode
    logic               in_accept;
    logic               row_ok;
    logic [CNT_W-1:0]   n_eff;
    logic [CNT_W-1:0]   n_last;
    logic               seed_ok;
    logic [ROUND_W-1:0] nxt_round;
    logic               i_last;
    logic               j_last;
    logic               k_last;
    logic               node_live;
    logic               eligible;
    logic               out_free;
    logic               run_more;

    gse_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gse_draw_unit u_draw (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (draw_ctrl),
        .seed    (cfg.random_seed),
        .percent (draw_percent),
        .hit     (draw_hit)
    );

    // Adjacency rows, written by input beats, read once per node visit
    gse_ram #(
        .WIDTH (NODES),
        .DEPTH (NODES)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (row_index[IDX_W-1:0]),
        .wdata (neighbours[NODES-1:0]),
        .re    (adj_re),
        .raddr (i_reg),
        .rdata (adj_rdata)
    );

    // Round stamp per node; only meaningful while the node's infected flag is set
    gse_ram #(
        .WIDTH (ROUND_W),
        .DEPTH (NODES)
    ) u_round_ram (
        .clk   (clk),
        .we    (rnd_we),
        .waddr (rnd_waddr),
        .wdata (rnd_wdata),
        .re    (rnd_re),
        .raddr (rnd_raddr),
        .rdata (rnd_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid & in_ready;
    assign row_ok    = (CNT_W'(row_index) < CNT_W'(NODES));

    // Clamp node_count into 1..NODES
    always_comb
    begin
        if (cfg.node_count == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (cfg.node_count > CNT_W'(NODES))
        begin
            n_eff = CNT_W'(NODES);
        end
        else
        begin
            n_eff = cfg.node_count;
        end
    end

    assign n_last    = n_eff - CNT_W'(1);
    assign seed_ok   = (CNT_W'(cfg.seed_node) < n_eff);
    assign nxt_round = cur_reg + ROUND_W'(1);
    assign i_last    = (CNT_W'(i_reg) == n_last);
    assign j_last    = (CNT_W'(j_reg) == n_last);
    assign k_last    = (CNT_W'(k_reg) == n_last);
    assign node_live = inf_reg[i_reg] & ~imm_reg[i_reg] & (rnd_rdata == cur_reg);
    assign eligible  = adj_rdata[j_reg] & ~inf_reg[j_reg] & ~imm_reg[j_reg];
    assign out_free  = ~out_valid_reg | out_ready;
    assign run_more  = (active_reg != '0) && (cur_reg < ROUND_W'(MAX_ROUNDS));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && last_row)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                state_next = run_more ? ST_NODE_RD : ST_EMIT_RD;
            end
            ST_NODE_RD:
            begin
                state_next = ST_NODE_EVAL;
            end
            ST_NODE_EVAL:
            begin
                if (node_live)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = i_last ? ST_ROUND : ST_NODE_RD;
                end
            end
            ST_SCAN:
            begin
                if (j_last)
                begin
                    state_next = ST_RECOVER;
                end
            end
            ST_RECOVER:
            begin
                state_next = i_last ? ST_ROUND : ST_NODE_RD;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_PUT;
            end
            ST_EMIT_PUT:
            begin
                if (out_free)
                begin
                    state_next = k_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath control per state
    always_comb
    begin
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        active_next    = active_reg;
        inf_next       = inf_reg;
        imm_next       = imm_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        out_load       = 1'b0;
        adj_we         = 1'b0;
        adj_re         = 1'b0;
        rnd_we         = 1'b0;
        rnd_waddr      = i_reg;
        rnd_wdata      = nxt_round;
        rnd_re         = 1'b0;
        rnd_raddr      = i_reg;
        draw_ctrl      = '0;
        draw_percent   = cfg.recover_percent;

        case (state_reg)
            ST_IDLE:
            begin
                // Store the row; a row beyond the graph is dropped
                adj_we = in_accept & row_ok;
            end
            ST_INIT:
            begin
                // Clear node flags, reload the LFSR, seed the first infection
                inf_next       = '0;
                imm_next       = '0;
                cur_next       = '0;
                draw_ctrl.load = 1'b1;
                active_next    = '0;
                if (seed_ok)
                begin
                    inf_next[cfg.seed_node[IDX_W-1:0]] = 1'b1;
                    active_next = CNT_W'(1);
                    rnd_we      = 1'b1;
                    rnd_waddr   = cfg.seed_node[IDX_W-1:0];
                    rnd_wdata   = '0;
                end
            end
            ST_ROUND:
            begin
                i_next = '0;
                k_next = '0;
            end
            ST_NODE_RD:
            begin
                adj_re = 1'b1;
                rnd_re = 1'b1;
            end
            ST_NODE_EVAL:
            begin
                if (node_live)
                begin
                    j_next = '0;
                end
                else if (i_last)
                begin
                    cur_next = nxt_round;
                end
                else
                begin
                    i_next = i_reg + IDX_W'(1);
                end
            end
            ST_SCAN:
            begin
                // One neighbour per cycle; only eligible ones consume a draw
                draw_percent   = cfg.infect_percent;
                draw_ctrl.step = eligible;
                if (eligible && draw_hit)
                begin
                    inf_next[j_reg] = 1'b1;
                    active_next     = active_reg + CNT_W'(1);
                    rnd_we          = 1'b1;
                    rnd_waddr       = j_reg;
                end
                if (!j_last)
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            ST_RECOVER:
            begin
                draw_ctrl.step = 1'b1;
                if (draw_hit)
                begin
                    imm_next[i_reg] = 1'b1;
                    active_next     = active_reg - CNT_W'(1);
                end
                else
                begin
                    rnd_we    = 1'b1;
                    rnd_waddr = i_reg;
                end
                if (i_last)
                begin
                    cur_next = nxt_round;
                end
                else
                begin
                    i_next = i_reg + IDX_W'(1);
                end
            end
            ST_EMIT_RD:
            begin
                rnd_re    = 1'b1;
                rnd_raddr = k_reg;
            end
            ST_EMIT_PUT:
            begin
                // Hold until the output register frees up
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    if (!k_last)
                    begin
                        k_next = k_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            cur_reg       <= '0;
            active_reg    <= '0;
            inf_reg       <= '0;
            imm_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            cur_reg       <= cur_next;
            active_reg    <= active_next;
            inf_reg       <= inf_next;
            imm_reg       <= imm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload; a node never infected reports round zero
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            node_index_reg    <= NODE_W'(k_reg);
            ever_infected_reg <= inf_reg[k_reg];
            final_round_reg   <= inf_reg[k_reg] ? rnd_rdata : '0;
            recovered_reg     <= imm_reg[k_reg];
            rounds_run_reg    <= cur_reg;
            hit_limit_reg     <= (active_reg != '0);
            last_node_reg     <= k_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign node_index    = node_index_reg;
    assign ever_infected = ever_infected_reg;
    assign final_round   = final_round_reg;
    assign recovered     = recovered_reg;
    assign rounds_run    = rounds_run_reg;
    assign hit_limit     = hit_limit_reg;
    assign last_node     = last_node_reg;

`ifndef SYNTHESIS
    a_active_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(inf_reg & ~imm_reg) == int'(active_reg))
        else $error("active count disagrees with infectious node flags");

    a_immune_was_infected: assert property (@(posedge clk) disable iff (!rst_n)
        (imm_reg & ~inf_reg) == '0)
        else $error("node became immune without ever being infected");

    a_round_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg <= ROUND_W'(MAX_ROUNDS))
        else $error("round counter ran past the round cap");
`endif

endmodule

`default_nettype wire

FILE: tb/graph_sir_epidemic_engine_checker.sv
// Outcome checker for the graph SIR epidemic engine: predicts each run and compares results.
`timescale 1ns / 1ps

module graph_sir_epidemic_engine_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gse_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [gse_pkg::APB_DATA_W-1:0]  pwdata,
    input  logic                            pready,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [gse_pkg::NODE_W-1:0]      row_index,
    input  logic [gse_pkg::ROW_W-1:0]       neighbours,
    input  logic                            last_row,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [gse_pkg::NODE_W-1:0]      node_index,
    input  logic                            ever_infected,
    input  logic [gse_pkg::ROUND_W-1:0]     final_round,
    input  logic                            recovered,
    input  logic [gse_pkg::ROUND_W-1:0]     rounds_run,
    input  logic                            hit_limit,
    input  logic                            last_node,
    output int                              mismatches,
    output int                              outstanding
);

    import gse_pkg::*;

    typedef struct packed {
        logic [NODE_W-1:0]  node;
        logic               ever;
        logic [ROUND_W-1:0] last_round;
        logic               immune;
        logic [ROUND_W-1:0] rounds;
        logic               limit;
        logic               tail;
    } node_outcome_t;

    node_outcome_t expected_outcomes[$];

    // Shadow of the block's registers and run state
    logic [PCT_W-1:0]   infect_pct;
    logic [PCT_W-1:0]   recover_pct;
    logic [CNT_W-1:0]   node_cnt;
    logic [NODE_W-1:0]  seed_idx;
    logic [SEED_W-1:0]  seed_word;
    logic [ROW_W-1:0]   adj_rows [NODES];
    logic [ROUND_W-1:0] inf_round [NODES];
    bit                 infected [NODES];
    bit                 immune [NODES];
    logic [SEED_W-1:0]  lfsr;

    task automatic report_mismatch(input string text);
        $display("%0t outcome_check: %s", $realtime, text);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input int node,
                                 input logic [6:0] got, input logic [6:0] want);
        if (got !== want)
            report_mismatch($sformatf("node %0d %s: got %0d, want %0d",
                                      node, name, got, want));
    endtask

    // Advance the LFSR one step and scale its low half to 0..99
    function automatic logic [PCT_W-1:0] pct_draw();
        logic              carry;
        logic [31:0]       scaled;
        carry = lfsr[0];
        lfsr = lfsr >> 1;
        if (carry)
            lfsr = lfsr ^ LFSR_TAPS;
        scaled = {16'd0, lfsr[DRAW_FRAC_W-1:0]} * PERCENT_SCALE;
        return PCT_W'(scaled >> DRAW_FRAC_W);
    endfunction

    function automatic void predict_outbreak();
        int                 n;
        int                 i;
        int                 j;
        int                 active;
        logic [ROW_W-1:0]   use_mask;
        logic [ROW_W-1:0]   row;
        logic [ROUND_W-1:0] rnd;
        logic [ROUND_W-1:0] nxt;
        node_outcome_t      res;
        n = (node_cnt == 0) ? 1 : ((node_cnt > NODES) ? NODES : int'(node_cnt));
        use_mask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        for (i = 0; i < NODES; i++)
        begin
            inf_round[i] = '0;
            infected[i] = 1'b0;
            immune[i] = 1'b0;
        end
        lfsr = (seed_word == 0) ? 32'd1 : seed_word;
        rnd = '0;
        if (int'(seed_idx) < n)
        begin
            infected[seed_idx] = 1'b1;
            active = 1;
        end
        else
        begin
            active = 0;
        end
        while (active > 0 && rnd < MAX_ROUNDS)
        begin
            nxt = rnd + 7'd1;
            for (i = 0; i < n; i++)
            begin
                if (infected[i] && !immune[i] && inf_round[i] == rnd)
                begin
                    row = adj_rows[i] & use_mask;
                    for (j = 0; j < n; j++)
                    begin
                        if (row[j] && !infected[j] && !immune[j])
                        begin
                            if (pct_draw() < infect_pct)
                            begin
                                infected[j] = 1'b1;
                                inf_round[j] = nxt;
                                active++;
                            end
                        end
                    end
                    if (pct_draw() < recover_pct)
                    begin
                        immune[i] = 1'b1;
                        active--;
                    end
                    else
                    begin
                        inf_round[i] = nxt;
                    end
                end
            end
            rnd = nxt;
        end
        for (i = 0; i < n; i++)
        begin
            res.node = i[NODE_W-1:0];
            res.ever = infected[i];
            res.last_round = infected[i] ? inf_round[i] : '0;
            res.immune = immune[i];
            res.rounds = rnd;
            res.limit = (active > 0);
            res.tail = (i == n - 1);
            expected_outcomes.push_back(res);
        end
    endfunction

    function automatic void apply_reg_write(input logic [APB_ADDR_W-1:0] addr,
                                            input logic [APB_DATA_W-1:0] data);
        case (addr[REG_SEL_W+1:2])
            REG_INFECT_PERCENT:  infect_pct = data[PCT_W-1:0];
            REG_RECOVER_PERCENT: recover_pct = data[PCT_W-1:0];
            REG_NODE_COUNT:      node_cnt = data[CNT_W-1:0];
            REG_SEED_NODE:       seed_idx = data[NODE_W-1:0];
            REG_RANDOM_SEED:     seed_word = data[SEED_W-1:0];
            default: ;
        endcase
    endfunction

    task automatic check_outcome();
        node_outcome_t want;
        if (expected_outcomes.size() == 0)
        begin
            report_mismatch($sformatf("result beat for node %0d with none expected",
                                      node_index));
            return;
        end
        want = expected_outcomes.pop_front();
        compare_field("node_index", int'(want.node), ROUND_W'(node_index),
                      ROUND_W'(want.node));
        compare_field("ever_infected", int'(want.node), ROUND_W'(ever_infected),
                      ROUND_W'(want.ever));
        compare_field("final_round", int'(want.node), final_round, want.last_round);
        compare_field("recovered", int'(want.node), ROUND_W'(recovered),
                      ROUND_W'(want.immune));
        compare_field("rounds_run", int'(want.node), rounds_run, want.rounds);
        compare_field("hit_limit", int'(want.node), ROUND_W'(hit_limit),
                      ROUND_W'(want.limit));
        compare_field("last_node", int'(want.node), ROUND_W'(last_node),
                      ROUND_W'(want.tail));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            infect_pct = INFECT_RESET;
            recover_pct = RECOVER_RESET;
            node_cnt = COUNT_RESET;
            seed_idx = SEED_RESET;
            seed_word = RANDOM_RESET;
            expected_outcomes.delete();
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                apply_reg_write(paddr, pwdata);
            if (out_valid && out_ready)
                check_outcome();
            if (in_valid && in_ready)
            begin
                adj_rows[row_index] = neighbours;
                if (last_row)
                    predict_outbreak();
            end
            outstanding <= expected_outcomes.size();
        end
    end

endmodule

FILE: tb/graph_sir_epidemic_engine_tb.sv
// Top of the graph SIR epidemic engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module graph_sir_epidemic_engine_tb;

    import gse_pkg::*;

    // Hang guard only; a correct run needs a small fraction of this
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int RANDOM_BEATS  = 320;
    // Cycles to let the emit sequencer wind down before touching registers
    localparam int SETTLE_CYCLES = 40;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr = '0;
    logic [APB_DATA_W-1:0]   pwdata = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [NODE_W-1:0]       row_index = '0;
    logic [ROW_W-1:0]        neighbours = '0;
    logic                    last_row = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [NODE_W-1:0]       node_index;
    logic                    ever_infected;
    logic [ROUND_W-1:0]      final_round;
    logic                    recovered;
    logic [ROUND_W-1:0]      rounds_run;
    logic                    hit_limit;
    logic                    last_node;

    int                      mismatches;
    int                      outstanding;
    int                      beats_sent;
    int                      cycle_count;
    // When set, both sides stream back to back with no idle cycles
    bit                      calm;
    // Rows written since reset; a run must never read any other row
    logic [NODES-1:0]        rows_loaded;
    logic [CNT_W-1:0]        node_count_cfg;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    graph_sir_epidemic_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .row_index     (row_index),
        .neighbours    (neighbours),
        .last_row      (last_row),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .node_index    (node_index),
        .ever_infected (ever_infected),
        .final_round   (final_round),
        .recovered     (recovered),
        .rounds_run    (rounds_run),
        .hit_limit     (hit_limit),
        .last_node     (last_node)
    );

    graph_sir_epidemic_engine_checker outcome_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .row_index     (row_index),
        .neighbours    (neighbours),
        .last_row      (last_row),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .node_index    (node_index),
        .ever_infected (ever_infected),
        .final_round   (final_round),
        .recovered     (recovered),
        .rounds_run    (rounds_run),
        .hit_limit     (hit_limit),
        .last_node     (last_node),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Number of nodes a run really walks for a given node_count value
    function automatic int active_nodes(input logic [CNT_W-1:0] nc);
        if (nc == 0)
            return 1;
        if (nc > NODES)
            return NODES;
        return int'(nc);
    endfunction

    // Mix empty, full, sparse and dense adjacency rows
    function automatic logic [ROW_W-1:0] random_row();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Setup cycle, then access cycle; the register takes the value at the access edge.
    // Then drop psel and idle the bus so back-to-back writes never collide in one step.
    task automatic write_reg(input logic [REG_SEL_W-1:0] sel,
                             input logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Present one row beat and hold it until the block takes it. Valid stays high
    // on return so a zero-gap follow-up beat streams without a bubble.
    task automatic send_row(input logic [NODE_W-1:0] idx, input logic [ROW_W-1:0] nb,
                            input logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        row_index <= idx;
        neighbours <= nb;
        last_row <= last;
        do @(posedge clk); while (in_ready !== 1'b1);
        rows_loaded[idx] = 1'b1;
        beats_sent++;
    endtask

    // Drop valid, wait for every predicted result, then let the block go quiet
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Reprogram all registers from an idle block
    task automatic configure(input logic [PCT_W-1:0] ip, input logic [PCT_W-1:0] rp,
                             input logic [CNT_W-1:0] nc, input logic [NODE_W-1:0] sn,
                             input logic [SEED_W-1:0] rs);
        settle();
        write_reg(REG_INFECT_PERCENT, APB_DATA_W'(ip));
        write_reg(REG_RECOVER_PERCENT, APB_DATA_W'(rp));
        write_reg(REG_NODE_COUNT, APB_DATA_W'(nc));
        write_reg(REG_SEED_NODE, APB_DATA_W'(sn));
        write_reg(REG_RANDOM_SEED, rs);
        node_count_cfg = nc;
    endtask

    // Fill any row in use that was never written, then start the run with the last beat
    task automatic launch_outbreak(input logic [NODE_W-1:0] idx, input logic [ROW_W-1:0] nb);
        int n;
        int i;
        n = active_nodes(node_count_cfg);
        for (i = 0; i < n; i++)
            if (!rows_loaded[i] && i != int'(idx))
                send_row(i[NODE_W-1:0], random_row(), 1'b0);
        send_row(idx, nb, 1'b1);
    endtask

    // Receiver: draw a stall per result beat, then hold ready until a beat moves
    initial
    begin
        int stall;
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    // Hang guard
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("graph_sir_epidemic_engine_tb: done, errors");
        $finish;
    end

    initial
    begin
        int                 beats_goal;
        int                 size_class;
        int                 eff;
        logic [PCT_W-1:0]   ip;
        logic [PCT_W-1:0]   rp;
        logic [CNT_W-1:0]   nc;
        logic [NODE_W-1:0]  sn;
        logic [SEED_W-1:0]  rs;
        bit                 first_phase;

        rows_loaded = '0;
        beats_sent = 0;
        calm = 1'b0;
        node_count_cfg = COUNT_RESET;

        // Hold reset, then release it once
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Certain spread and certain recovery; the full row also carries edges
        // to nodes past node_count, which must be ignored
        configure(7'd100, 7'd100, 7'd4, 6'd0, 32'd1);
        send_row(6'd1, '0, 1'b0);
        send_row(6'd2, '0, 1'b0);
        send_row(6'd3, '0, 1'b0);
        launch_outbreak(6'd0, '1);

        // No spread, no recovery: the seed stays infectious until the round cap
        configure(7'd0, 7'd0, 7'd2, 6'd1, 32'hFFFF_FFFF);
        send_row(6'd0, '0, 1'b0);
        launch_outbreak(6'd1, '1);

        // node_count zero acts as one node, zero seed word acts as one,
        // percentages above 100 act as certainty
        configure(7'd127, 7'd127, 7'd0, 6'd0, 32'd0);
        launch_outbreak(6'd0, 64'h2);

        // Seed outside the nodes in use: the run ends at once with nobody infected
        configure(7'd50, 7'd80, 7'd3, 6'd63, 32'h1234_5678);
        launch_outbreak(6'd2, 64'h5);

        // Everyone gets infected and nobody recovers: stop at the cap with
        // all nodes still infectious
        configure(7'd120, 7'd0, 7'd3, 6'd2, 32'hDEAD_BEEF);
        send_row(6'd0, 64'h2, 1'b0);
        send_row(6'd2, 64'h1, 1'b0);
        launch_outbreak(6'd1, 64'h4);

        // Top row index, then a mid-sized run with a fully connected tail row
        configure(7'd60, 7'd40, 7'd8, 6'd5, 32'h0000_ACE1);
        send_row(6'd63, '1, 1'b0);
        launch_outbreak(6'd7, '1);

        // Zero infection chance with certain recovery
        configure(7'd0, 7'd100, 7'd5, 6'd4, 32'h8000_0000);
        launch_outbreak(6'd4, '1);

        // Random part: mostly small graphs, a few mid-sized, rarely the full size
        beats_goal = beats_sent + RANDOM_BEATS;
        first_phase = 1'b1;
        while (beats_sent < beats_goal)
        begin
            if (first_phase || $urandom_range(0, 3) == 0)
            begin
                first_phase = 1'b0;
                size_class = $urandom_range(0, 9);
                if (size_class == 0)
                begin
                    nc = ($urandom_range(0, 1) == 0) ? 7'd64
                                                     : CNT_W'($urandom_range(65, 127));
                    rp = PCT_W'($urandom_range(60, 127));
                end
                else if (size_class == 1)
                begin
                    nc = CNT_W'($urandom_range(9, 24));
                    rp = PCT_W'($urandom_range(20, 127));
                end
                else
                begin
                    nc = CNT_W'($urandom_range(0, 8));
                    rp = PCT_W'($urandom_range(0, 127));
                end
                eff = active_nodes(nc);
                ip = PCT_W'($urandom_range(0, 127));
                // Now and then seed anywhere, which may fall outside the graph
                if ($urandom_range(0, 7) == 0)
                    sn = NODE_W'($urandom_range(0, 63));
                else
                    sn = NODE_W'($urandom_range(0, eff - 1));
                rs = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom;
                calm = ($urandom_range(0, 3) == 0);
                configure(ip, rp, nc, sn, rs);
            end
            // Stray rows that start nothing, then a well-formed run
            repeat ($urandom_range(0, 4))
                send_row(6'($urandom_range(0, 63)), random_row(), 1'b0);
            launch_outbreak(6'($urandom_range(0, 63)), random_row());
            // Sometimes hold off until the whole result stream has drained
            if ($urandom_range(0, 5) == 0)
                settle();
        end

        settle();
        if (mismatches == 0)
            $display("graph_sir_epidemic_engine_tb: done, clean");
        else
            $display("graph_sir_epidemic_engine_tb: done, errors");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/gse_pkg.sv
hw/rtl/gse_ram.sv
hw/rtl/gse_draw_unit.sv
hw/rtl/gse_cfg_regs.sv
hw/rtl/graph_sir_epidemic_engine.sv
tb/graph_sir_epidemic_engine_checker.sv
tb/graph_sir_epidemic_engine_tb.sv
